@@ src/rrfe_pkg.sv @@
`default_nettype none
package rrfe_pkg;

  // ring geometry
  localparam int unsigned RING_BYTES = 8192;
  localparam int unsigned OFF_W      = $clog2(RING_BYTES);

  // field widths
  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned WORD_W   = 16;
  localparam int unsigned LEN_W    = 12;
  localparam int unsigned CNT_W    = 14;
  localparam int unsigned CFG_W    = 13;
  localparam int unsigned CFG_IDX_W = 1;

  // record constants
  localparam logic [WORD_W-1:0] MAX_LEN_FIELD   = 16'h2000;
  localparam logic [WORD_W-1:0] HDR_BYTES_W     = 16'd4;
  localparam logic [CNT_W-1:0]  HDR_BYTES       = 14'd4;
  localparam logic [LEN_W-1:0]  DEFAULT_PAYLOAD = 12'd1514;
  localparam logic [LEN_W-1:0]  PAYLOAD_CAP     = 12'd2048;
  localparam logic [OFF_W-1:0]  RP_BACKOFF      = OFF_W'(16);
  localparam logic [OFF_W-1:0]  RING_LAST       = OFF_W'(RING_BYTES - 1);

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_START_OFFSET = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_PAYLOAD  = 1'b1;

  // result kinds
  localparam logic KIND_PAYLOAD = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  typedef enum logic [1:0] {
    OUT_OK         = 2'd0,
    OUT_STATUS_ERR = 2'd1,
    OUT_BAD_LEN    = 2'd2
  } outcome_e;

  typedef struct packed {
    logic              valid;
    logic              kind;
    logic [BYTE_W-1:0] data;
    logic              last;
    logic [LEN_W-1:0]  frame_len;
    outcome_e          outcome;
    logic [OFF_W-1:0]  next_offset;
    logic [OFF_W-1:0]  read_pointer;
  } rrfe_result_t;

  // handshake between the input register and the step logic
  typedef struct packed {
    logic              valid;
    logic [BYTE_W-1:0] ring_byte;
  } rrfe_item_t;

  // outcome of a record from its header words
  function automatic outcome_e record_outcome(logic [WORD_W-1:0] status_w,
                                              logic [WORD_W-1:0] length_w);
    outcome_e oc;
    if (length_w < HDR_BYTES_W || length_w > MAX_LEN_FIELD) begin
      oc = OUT_BAD_LEN;
    end else if (!status_w[0]) begin
      oc = OUT_STATUS_ERR;
    end else begin
      oc = OUT_OK;
    end
    return oc;
  endfunction

endpackage
`default_nettype wire

@@ src/rrfe_in_stage.sv @@
`default_nettype none
module rrfe_in_stage (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       in_valid_i,
  output logic                            in_ready_o,
  input  wire logic [rrfe_pkg::BYTE_W-1:0] ring_byte_i,
  input  wire logic                       take_i,
  output rrfe_pkg::rrfe_item_t            item_o
);
  import rrfe_pkg::*;

  logic              valid_q, valid_d;
  logic [BYTE_W-1:0] byte_q;

  // room when empty or when the held item moves on this cycle
  assign in_ready_o = !valid_q || take_i;

  always_comb begin
    valid_d = valid_q;
    if (in_ready_o) begin
      valid_d = in_valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      byte_q <= ring_byte_i;
    end
  end

  assign item_o.valid     = valid_q;
  assign item_o.ring_byte = byte_q;

endmodule
`default_nettype wire

@@ src/rrfe_step.sv @@
`default_nettype none
module rrfe_step (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [rrfe_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [rrfe_pkg::CFG_W-1:0]    cfg_data_i,
  input  wire rrfe_pkg::rrfe_item_t          item_i,
  input  wire logic                          out_free_i,
  output logic                               take_o,
  output rrfe_pkg::rrfe_result_t             res_o
);
  import rrfe_pkg::*;

  localparam logic [1:0] PH_HEADER  = 2'd0;
  localparam logic [1:0] PH_PAYLOAD = 2'd1;
  localparam logic [1:0] PH_TRAILER = 2'd2;

  logic [OFF_W-1:0]  ring_offset_q, ring_offset_d;
  logic [1:0]        phase_q, phase_d;
  logic [1:0]        header_count_q, header_count_d;
  logic [WORD_W-1:0] status_word_q, status_word_d;
  logic [WORD_W-1:0] length_word_q, length_word_d;
  logic [CNT_W-1:0]  byte_count_q, byte_count_d;
  logic [CNT_W-1:0]  record_total_q, record_total_d;
  logic [LEN_W-1:0]  deliver_len_q, deliver_len_d;
  logic [LEN_W-1:0]  max_payload_q;

  logic [OFF_W-1:0]  next_off;
  logic [CNT_W-1:0]  bc_inc;
  logic [WORD_W-1:0] new_length;
  outcome_e          hdr_oc, rec_oc;
  logic [1:0]        mis;
  logic [CNT_W-1:0]  body;
  logic [CNT_W-1:0]  aligned_end;
  logic [LEN_W-1:0]  cap;
  logic [WORD_W-1:0] pay_len;
  logic              has_res;
  rrfe_result_t      res;

  // ring offset after this byte
  assign next_off = (ring_offset_q == RING_LAST) ? '0 : ring_offset_q + 1'b1;
  assign bc_inc   = byte_count_q + 1'b1;

  // header decode, used on the fourth header byte
  assign new_length  = {item_i.ring_byte, length_word_q[7:0]};
  assign hdr_oc      = record_outcome(status_word_q, new_length);
  assign rec_oc      = record_outcome(status_word_q, length_word_q);
  assign mis         = ring_offset_q[1:0] + 2'd1;
  assign body        = (hdr_oc == OUT_BAD_LEN) ? HDR_BYTES : new_length[CNT_W-1:0];
  assign aligned_end = (CNT_W'(mis) + HDR_BYTES + body + CNT_W'(3)) & ~CNT_W'(3);
  assign cap         = (max_payload_q > PAYLOAD_CAP) ? PAYLOAD_CAP : max_payload_q;
  assign pay_len     = new_length - HDR_BYTES_W;

  // step logic for the held item
  always_comb begin
    ring_offset_d  = next_off;
    phase_d        = phase_q;
    header_count_d = header_count_q;
    status_word_d  = status_word_q;
    length_word_d  = length_word_q;
    byte_count_d   = byte_count_q;
    record_total_d = record_total_q;
    deliver_len_d  = deliver_len_q;
    has_res        = 1'b0;
    res            = '0;
    case (phase_q)
      PH_PAYLOAD: begin
        has_res      = 1'b1;
        res.kind     = KIND_PAYLOAD;
        res.data     = item_i.ring_byte;
        byte_count_d = bc_inc;
        if (byte_count_q - CNT_W'(3) >= CNT_W'(deliver_len_q)) begin
          res.last = 1'b1;
          phase_d  = PH_TRAILER;
        end
      end
      PH_TRAILER: begin
        byte_count_d = bc_inc;
        if (bc_inc >= record_total_q) begin
          has_res          = 1'b1;
          res.kind         = KIND_SUMMARY;
          res.frame_len    = (rec_oc == OUT_OK) ? deliver_len_q : '0;
          res.outcome      = rec_oc;
          res.next_offset  = next_off;
          res.read_pointer = next_off - RP_BACKOFF;
          phase_d          = PH_HEADER;
          header_count_d   = '0;
          byte_count_d     = '0;
        end
      end
      default: begin
        case (header_count_q)
          2'd0: status_word_d = {status_word_q[15:8], item_i.ring_byte};
          2'd1: status_word_d = {item_i.ring_byte, status_word_q[7:0]};
          2'd2: length_word_d = {length_word_q[15:8], item_i.ring_byte};
          default: length_word_d = new_length;
        endcase
        if (header_count_q != 2'd3) begin
          header_count_d = header_count_q + 1'b1;
          phase_d        = PH_HEADER;
        end else begin
          record_total_d = aligned_end - CNT_W'(mis);
          deliver_len_d  = '0;
          if (hdr_oc == OUT_OK) begin
            deliver_len_d = (pay_len > WORD_W'(cap)) ? cap : pay_len[LEN_W-1:0];
          end
          header_count_d = '0;
          byte_count_d   = HDR_BYTES;
          phase_d        = (deliver_len_d != '0) ? PH_PAYLOAD : PH_TRAILER;
        end
      end
    endcase
  end

  assign take_o    = item_i.valid && (!has_res || out_free_i);
  always_comb begin
    res_o       = res;
    res_o.valid = take_o && has_res;
  end

  // state registers, restarted by a start offset write
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ring_offset_q  <= '0;
      phase_q        <= PH_HEADER;
      header_count_q <= '0;
      status_word_q  <= '0;
      length_word_q  <= '0;
      byte_count_q   <= '0;
      record_total_q <= '0;
      deliver_len_q  <= '0;
    end else if (cfg_we_i && cfg_index_i == CFG_START_OFFSET) begin
      ring_offset_q  <= OFF_W'(cfg_data_i);
      phase_q        <= PH_HEADER;
      header_count_q <= '0;
      status_word_q  <= '0;
      length_word_q  <= '0;
      byte_count_q   <= '0;
      record_total_q <= '0;
      deliver_len_q  <= '0;
    end else if (take_o) begin
      ring_offset_q  <= ring_offset_d;
      phase_q        <= phase_d;
      header_count_q <= header_count_d;
      status_word_q  <= status_word_d;
      length_word_q  <= length_word_d;
      byte_count_q   <= byte_count_d;
      record_total_q <= record_total_d;
      deliver_len_q  <= deliver_len_d;
    end
  end

  // payload limit register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_payload_q <= DEFAULT_PAYLOAD;
    end else if (cfg_we_i && cfg_index_i == CFG_MAX_PAYLOAD) begin
      max_payload_q <= cfg_data_i[LEN_W-1:0];
    end
  end

endmodule
`default_nettype wire

@@ src/rrfe_out_stage.sv @@
`default_nettype none
module rrfe_out_stage (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire rrfe_pkg::rrfe_result_t res_i,
  output logic                       free_o,
  output logic                       out_valid_o,
  input  wire logic                  out_ready_i,
  output rrfe_pkg::rrfe_result_t     res_o
);
  import rrfe_pkg::*;

  logic         valid_q, valid_d;
  rrfe_result_t res_q;

  // register free when empty or being drained
  assign free_o = !valid_q || out_ready_i;

  always_comb begin
    valid_d = valid_q;
    if (res_i.valid) begin
      valid_d = 1'b1;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_i.valid) begin
      res_q <= res_i;
    end
  end

  assign out_valid_o = valid_q;
  assign res_o       = res_q;

endmodule
`default_nettype wire

@@ src/rx_ring_frame_extractor_unit.sv @@
// path: an accepted byte is held in the input register and stepped by the step logic;
//   any result it gives is loaded into the output register
// throughput: one ring byte per cycle while the output has room; single step stage
// reset: asynchronous active low; ring offset 0, header phase, max payload 1514
`default_nettype none
module rx_ring_frame_extractor_unit (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic [rrfe_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [rrfe_pkg::CFG_W-1:0]     cfg_data_i,
  input  wire logic                           in_valid_i,
  output logic                                in_ready_o,
  input  wire logic [rrfe_pkg::BYTE_W-1:0]    ring_byte_i,
  output logic                                out_valid_o,
  input  wire logic                           out_ready_i,
  output logic                                kind_o,
  output logic [rrfe_pkg::BYTE_W-1:0]         data_o,
  output logic                                last_o,
  output logic [rrfe_pkg::LEN_W-1:0]          frame_len_o,
  output logic [1:0]                          outcome_o,
  output logic [rrfe_pkg::OFF_W-1:0]          next_offset_o,
  output logic [rrfe_pkg::OFF_W-1:0]          read_pointer_o
);
  import rrfe_pkg::*;

  rrfe_item_t   item;
  rrfe_result_t step_res;
  rrfe_result_t out_res;
  logic         take;
  logic         out_free;

  // input register
  rrfe_in_stage u_in (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .ring_byte_i (ring_byte_i),
    .take_i      (take),
    .item_o      (item)
  );

  // record parsing
  rrfe_step u_step (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .item_i      (item),
    .out_free_i  (out_free),
    .take_o      (take),
    .res_o       (step_res)
  );

  // result register
  rrfe_out_stage u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_i       (step_res),
    .free_o      (out_free),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .res_o       (out_res)
  );

  assign kind_o         = out_res.kind;
  assign data_o         = out_res.data;
  assign last_o         = out_res.last;
  assign frame_len_o    = out_res.frame_len;
  assign outcome_o      = out_res.outcome;
  assign next_offset_o  = out_res.next_offset;
  assign read_pointer_o = out_res.read_pointer;

  // a held input item that does not move keeps its byte
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    item.valid && !take |=> item.valid && $stable(item.ring_byte))
    else $error("held input item lost or changed");

  // a new result is only loaded when the output register has room
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_res.valid |-> out_free)
    else $error("result loaded over a waiting result");

  // a record-end item carries the read pointer sixteen bytes behind the offset
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o == KIND_SUMMARY |->
      read_pointer_o == OFF_W'(next_offset_o - RP_BACKOFF) && !last_o)
    else $error("bad read pointer on record end");

endmodule
`default_nettype wire

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps
module tb_top;
  import rrfe_pkg::*;

  localparam int N_PHASES       = 7;
  localparam int RAND_PER_PHASE = 130;
  localparam int SETTLE         = 6;

  // expected record-extractor output, one per result item
  typedef struct packed {
    logic              kind;
    logic [BYTE_W-1:0] data;
    logic              last;
    logic [LEN_W-1:0]  frame_len;
    outcome_e          outcome;
    logic [OFF_W-1:0]  next_offset;
    logic [OFF_W-1:0]  read_pointer;
  } deframe_out_t;

  typedef enum logic [1:0] {
    ST_HEADER  = 2'd0,
    ST_PAYLOAD = 2'd1,
    ST_TRAILER = 2'd2
  } rx_phase_e;

  logic                 clk_i       = 1'b0;
  logic                 rst_ni      = 1'b0;
  logic                 cfg_we_i    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index_i = CFG_START_OFFSET;
  logic [CFG_W-1:0]     cfg_data_i  = '0;
  logic                 in_valid_i  = 1'b0;
  logic                 in_ready_o;
  logic [BYTE_W-1:0]    ring_byte_i = '0;
  logic                 out_valid_o;
  logic                 out_ready_i = 1'b1;
  logic                 kind_o;
  logic [BYTE_W-1:0]    data_o;
  logic                 last_o;
  logic [LEN_W-1:0]     frame_len_o;
  logic [1:0]           outcome_o;
  logic [OFF_W-1:0]     next_offset_o;
  logic [OFF_W-1:0]     read_pointer_o;

  rx_ring_frame_extractor_unit dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .ring_byte_i    (ring_byte_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .kind_o         (kind_o),
    .data_o         (data_o),
    .last_o         (last_o),
    .frame_len_o    (frame_len_o),
    .outcome_o      (outcome_o),
    .next_offset_o  (next_offset_o),
    .read_pointer_o (read_pointer_o)
  );

  // clock
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // ring bytes waiting to be sent and results waiting to arrive
  logic [BYTE_W-1:0] ring_feed[$];
  deframe_out_t      pending_results[$];

  int unsigned errors     = 0;
  int unsigned bytes_in   = 0;
  int unsigned payload_seen = 0;
  int unsigned records_seen = 0;
  bit          byte_taken = 1'b0;
  bit          calm       = 1'b0;
  int unsigned in_gap     = 0;
  int unsigned out_gap    = 0;
  int unsigned gen_off    = 0;

  // deframer state mirror
  logic [OFF_W-1:0]  m_offset;
  rx_phase_e         m_phase;
  logic [1:0]        m_hdr_cnt;
  logic [WORD_W-1:0] m_status;
  logic [WORD_W-1:0] m_length;
  outcome_e          m_verdict;
  int unsigned       m_consumed;
  int unsigned       m_rec_total;
  int unsigned       m_deliver;
  logic [OFF_W-1:0]  m_start_off = '0;
  logic [LEN_W-1:0]  m_max_pay   = DEFAULT_PAYLOAD;

  task automatic ring_restart();
    m_offset    = m_start_off;
    m_phase     = ST_HEADER;
    m_hdr_cnt   = 2'd0;
    m_status    = '0;
    m_length    = '0;
    m_verdict   = OUT_OK;
    m_consumed  = 0;
    m_rec_total = 0;
    m_deliver   = 0;
  endtask

  // advance the mirror by one ring byte, queue any result it causes
  task automatic deframe_byte(input logic [BYTE_W-1:0] b);
    logic [OFF_W-1:0] cur;
    int unsigned      rec_start;
    int unsigned      mis;
    int unsigned      body;
    int unsigned      cap;
    int unsigned      idx;
    deframe_out_t     r;
    cur = m_offset;
    m_offset = (cur == RING_LAST) ? '0 : cur + 1'b1;
    r = '0;
    if (m_phase == ST_HEADER) begin
      case (m_hdr_cnt)
        2'd0: m_status[7:0] = b;
        2'd1: m_status[15:8] = b;
        2'd2: m_length[7:0] = b;
        default: m_length[15:8] = b;
      endcase
      if (m_hdr_cnt != 2'd3) begin
        m_hdr_cnt = m_hdr_cnt + 2'd1;
      end else begin
        // header complete: classify and size the record
        rec_start = (int'(cur) + RING_BYTES - 3) % RING_BYTES;
        mis = rec_start % 4;
        if (m_length < HDR_BYTES_W || m_length > MAX_LEN_FIELD) begin
          m_verdict = OUT_BAD_LEN;
        end else if (!m_status[0]) begin
          m_verdict = OUT_STATUS_ERR;
        end else begin
          m_verdict = OUT_OK;
        end
        body = (m_verdict == OUT_BAD_LEN) ? int'(HDR_BYTES) : int'(m_length);
        cap = (m_max_pay > PAYLOAD_CAP) ? int'(PAYLOAD_CAP) : int'(m_max_pay);
        m_rec_total = ((mis + HDR_BYTES + body + 3) / 4) * 4 - mis;
        m_deliver = 0;
        if (m_verdict == OUT_OK) begin
          m_deliver = int'(m_length) - HDR_BYTES;
          if (m_deliver > cap) m_deliver = cap;
        end
        m_hdr_cnt = 2'd0;
        m_consumed = HDR_BYTES;
        m_phase = (m_deliver > 0) ? ST_PAYLOAD : ST_TRAILER;
      end
    end else begin
      idx = m_consumed;
      m_consumed = idx + 1;
      if (m_phase == ST_PAYLOAD) begin
        r.kind = KIND_PAYLOAD;
        r.data = b;
        if (idx - HDR_BYTES + 1 >= m_deliver) begin
          r.last = 1'b1;
          m_phase = ST_TRAILER;
        end
        pending_results.push_back(r);
      end else if (m_consumed >= m_rec_total) begin
        // last byte of the record: record-end summary
        r.kind = KIND_SUMMARY;
        r.frame_len = (m_verdict == OUT_OK) ? LEN_W'(m_deliver) : '0;
        r.outcome = m_verdict;
        r.next_offset = m_offset;
        r.read_pointer =
          OFF_W'((int'(m_offset) + RING_BYTES - int'(RP_BACKOFF)) % RING_BYTES);
        pending_results.push_back(r);
        m_phase = ST_HEADER;
        m_hdr_cnt = 2'd0;
        m_consumed = 0;
      end
    end
  endtask

  // build one record at the generator's ring offset
  task automatic make_record(input logic [WORD_W-1:0] st,
                             input logic [WORD_W-1:0] ln);
    int unsigned mis;
    int unsigned body;
    int unsigned span;
    mis = gen_off % 4;
    body = (ln < HDR_BYTES_W || ln > MAX_LEN_FIELD) ? int'(HDR_BYTES) : int'(ln);
    span = ((mis + HDR_BYTES + body + 3) / 4) * 4 - mis;
    ring_feed.push_back(st[7:0]);
    ring_feed.push_back(st[15:8]);
    ring_feed.push_back(ln[7:0]);
    ring_feed.push_back(ln[15:8]);
    repeat (span - HDR_BYTES) ring_feed.push_back(BYTE_W'($urandom));
    gen_off = (gen_off + span) % RING_BYTES;
  endtask

  // mostly good frames, some status errors and bad lengths
  task automatic add_random_record();
    int unsigned       pick;
    logic [WORD_W-1:0] st;
    logic [WORD_W-1:0] ln;
    pick = $urandom_range(0, 99);
    st = WORD_W'($urandom);
    if (pick < 12) begin
      if ($urandom_range(0, 1) == 0) ln = WORD_W'($urandom_range(0, 3));
      else ln = WORD_W'($urandom_range(32'h2001, 32'hFFFF));
    end else begin
      if ($urandom_range(0, 4) == 0) ln = WORD_W'($urandom_range(29, 120));
      else ln = WORD_W'($urandom_range(4, 28));
      st[0] = (pick >= 25);
    end
    make_record(st, ln);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_W-1:0] val);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    if (idx == CFG_START_OFFSET) begin
      m_start_off = val;
      ring_restart();
    end else begin
      m_max_pay = val[LEN_W-1:0];
    end
  endtask

  // block has taken every byte and returned every result
  task automatic wait_drained();
    do @(posedge clk_i);
    while (ring_feed.size() != 0 || in_valid_i || pending_results.size() != 0);
  endtask

  task automatic check_field(input string fname, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      errors++;
      $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h",
               $time, fname, want, got);
    end
  endtask

  // input driver
  always @(negedge clk_i) begin
    if (!in_valid_i || byte_taken) begin
      byte_taken = 1'b0;
      if (in_gap != 0) begin
        in_gap--;
        in_valid_i <= 1'b0;
      end else if (ring_feed.size() == 0) begin
        in_valid_i <= 1'b0;
      end else if (!calm && $urandom_range(0, 9) == 0) begin
        in_gap = $urandom_range(0, 16);
        in_valid_i <= 1'b0;
      end else begin
        in_valid_i  <= 1'b1;
        ring_byte_i <= ring_feed.pop_front();
      end
    end
  end

  // output stalls
  always @(negedge clk_i) begin
    if (out_gap != 0) begin
      out_gap--;
      out_ready_i <= 1'b0;
    end else if (!calm && $urandom_range(0, 11) == 0) begin
      out_gap = $urandom_range(0, 16);
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  // accepted input item feeds the mirror
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && in_ready_o) begin
      byte_taken = 1'b1;
      bytes_in++;
      deframe_byte(ring_byte_i);
    end
  end

  // result checker
  deframe_out_t seen_want;
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, actual kind=%0d data=0x%0h",
                 $time, kind_o, data_o);
        $display("  last=%0d len=%0d outcome=%0d next=%0d rp=%0d",
                 last_o, frame_len_o, outcome_o, next_offset_o, read_pointer_o);
      end else begin
        seen_want = pending_results.pop_front();
        if (seen_want.kind == KIND_SUMMARY) records_seen++;
        else payload_seen++;
        check_field("kind", seen_want.kind, kind_o);
        check_field("data", seen_want.data, data_o);
        check_field("last", seen_want.last, last_o);
        check_field("frame_len", seen_want.frame_len, frame_len_o);
        check_field("outcome", seen_want.outcome, outcome_o);
        check_field("next_offset", seen_want.next_offset, next_offset_o);
        check_field("read_pointer", seen_want.read_pointer, read_pointer_o);
      end
    end
  end

  // stimulus sequence
  initial begin
    int unsigned  ph;
    int unsigned  base;
    logic [CFG_W-1:0] so;
    logic [CFG_W-1:0] mp;
    ring_restart();
    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: empty payload, short frame with padding, zero length
    gen_off = 0;
    make_record(16'h0001, 16'd4);
    make_record(16'hFFFF, 16'd7);
    make_record(16'hFF01, 16'h0000);

    for (ph = 1; ph <= N_PHASES; ph++) begin
      wait_drained();
      repeat (SETTLE) @(posedge clk_i);
      case (ph)
        1: begin so = 13'd8190; mp = 13'd2048; end
        2: begin so = 13'd3;    mp = 13'd4095; end
        3: begin so = 13'd4093; mp = 13'd7;    end
        4: begin so = 13'd1;    mp = 13'd0;    end
        5: begin so = 13'd8191; mp = 13'd1;    end
        default: begin
          so = CFG_W'($urandom_range(0, RING_BYTES - 1));
          mp = CFG_W'($urandom_range(0, 8191));
        end
      endcase
      cfg_write(CFG_START_OFFSET, so);
      cfg_write(CFG_MAX_PAYLOAD, mp);
      @(negedge clk_i);
      cfg_we_i <= 1'b0;
      @(posedge clk_i);
      calm = (ph == N_PHASES);
      gen_off = so;
      // length one above the limit counts as a bad length
      if (ph == 3) make_record(16'h8001, MAX_LEN_FIELD + 16'd1);
      base = ring_feed.size();
      while (ring_feed.size() - base < RAND_PER_PHASE) add_random_record();
      // broken tail: stray bytes cut off by the next restart
      if ($urandom_range(0, 1) == 0) begin
        repeat ($urandom_range(1, 12)) ring_feed.push_back(BYTE_W'($urandom));
      end
    end

    wait_drained();
    repeat (SETTLE) @(posedge clk_i);
    $display("summary: %0d ring bytes over %0d settings,", bytes_in, N_PHASES + 1);
    $display("  %0d payload bytes and %0d record ends checked",
             payload_seen, records_seen);
    if (errors == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

  // watchdog
  initial begin
    #3_000_000;
    $display("tb_top: errors");
    $finish;
  end

endmodule
